>>> sv/ddo_pkg.sv
// Shared types, constants and helper functions for the differential drive odometry unit.
// Used by every design module of the block but ddo_checker; depends on nothing else.
package ddo_pkg;

	// Iterative divider sizing: dividend magnitude bits, divisor bits, radix-4 step count.
	localparam int DIV_W     = 56;
	localparam int DEN_W     = 24;
	localparam int DIV_STEPS = DIV_W / 2;

	// CORDIC sizing.
	localparam int COR_STEPS = 24;
	localparam int COR_XW    = 33;
	localparam int COR_ZW    = 28;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_CIRC  = 2'd0;
	localparam logic [1:0] REG_TRACK = 2'd1;
	localparam logic [1:0] REG_TICKS = 2'd2;
	localparam logic [23:0] CIRC_RESET  = 24'd41288;
	localparam logic [23:0] TRACK_RESET = 24'd28836;
	localparam logic [15:0] TICKS_RESET = 16'd30;

	// Fixed-point constants.
	localparam logic signed [32:0] Q16_PI      = 33'sd205887;
	localparam logic signed [32:0] Q16_TWO_PI  = 33'sd411775;
	localparam logic [23:0]        TWO_PI_DEN  = 24'd411775;
	localparam logic signed [27:0] Q24_PI      = 28'sd52707179;
	localparam logic signed [27:0] Q24_HALF_PI = 28'sd26353589;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [33:0] HEAD_MAX    = 34'sd262143;
	localparam logic signed [33:0] HEAD_MIN    = -34'sd262144;
	localparam logic signed [20:0] US_PER_S    = 21'sd1000000;
	localparam logic signed [63:0] RND_HALF    = 64'sd536870912;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_DIV_DL,
		OP_PUT_DL,
		OP_DIV_DR,
		OP_PUT_DR,
		OP_DIV_TH,
		OP_PUT_TH,
		OP_DIV_ANG,
		OP_PUT_ANG,
		OP_COR_GO,
		OP_MUL_X,
		OP_MUL_Y,
		OP_POSE,
		OP_DIV_VX,
		OP_PUT_VX,
		OP_DIV_VY,
		OP_PUT_VY,
		OP_DIV_VH,
		OP_PUT_VH,
		OP_LOAD_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV_DL,
		ST_WAIT_DL,
		ST_DIV_DR,
		ST_WAIT_DR,
		ST_DIV_TH,
		ST_WAIT_TH,
		ST_DIV_ANG,
		ST_WAIT_ANG,
		ST_COR,
		ST_WAIT_COR,
		ST_MUL_X,
		ST_MUL_Y,
		ST_POSE,
		ST_DIV_VX,
		ST_WAIT_VX,
		ST_DIV_VY,
		ST_WAIT_VY,
		ST_DIV_VH,
		ST_WAIT_VH,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cor_done;
		logic zero_time;
		logic out_busy;
	} status_t;

	// Arctangent of 2^-i in Q.24 radians.
	function automatic logic signed [COR_ZW-1:0] atan_q24(input logic [4:0] idx);
		logic signed [COR_ZW-1:0] r;
		case (idx)
			5'd0:    r = 28'sd13176795;
			5'd1:    r = 28'sd7778716;
			5'd2:    r = 28'sd4110060;
			5'd3:    r = 28'sd2086331;
			5'd4:    r = 28'sd1047214;
			5'd5:    r = 28'sd524117;
			5'd6:    r = 28'sd262123;
			5'd7:    r = 28'sd131069;
			5'd8:    r = 28'sd65536;
			5'd9:    r = 28'sd32768;
			5'd10:   r = 28'sd16384;
			5'd11:   r = 28'sd8192;
			5'd12:   r = 28'sd4096;
			5'd13:   r = 28'sd2048;
			5'd14:   r = 28'sd1024;
			5'd15:   r = 28'sd512;
			5'd16:   r = 28'sd256;
			5'd17:   r = 28'sd128;
			5'd18:   r = 28'sd64;
			5'd19:   r = 28'sd32;
			5'd20:   r = 28'sd16;
			5'd21:   r = 28'sd8;
			5'd22:   r = 28'sd4;
			5'd23:   r = 28'sd2;
			default: r = 28'sd0;
		endcase
		return r;
	endfunction

	// Clamp a wide signed value into 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [DIV_W-1:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -56'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> sv/ddo_channels.sv
// Valid/ready channel interfaces for the odometry unit: wheel tick samples in, poses out.
// Standalone; no package dependency.
interface ddo_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] front_left_ticks;
	logic signed [15:0] rear_left_ticks;
	logic signed [15:0] front_right_ticks;
	logic signed [15:0] rear_right_ticks;
	logic        [23:0] elapsed_us;

	modport source (
		output valid, front_left_ticks, rear_left_ticks, front_right_ticks,
		       rear_right_ticks, elapsed_us,
		input  ready
	);
	modport sink (
		input  valid, front_left_ticks, rear_left_ticks, front_right_ticks,
		       rear_right_ticks, elapsed_us,
		output ready
	);
endinterface

interface ddo_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [18:0] heading;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_heading;
	logic               zero_time;

	modport source (
		output valid, pos_x, pos_y, heading, vel_x, vel_y, vel_heading, zero_time,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, heading, vel_x, vel_y, vel_heading, zero_time,
		output ready
	);
endinterface

>>> sv/ddo_div.sv
// Shared radix-4 restoring divider, signed dividend by unsigned divisor, truncating.
// Depends on ddo_pkg.
module ddo_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ddo_pkg::DIV_W-1:0]    num,
	input  logic        [ddo_pkg::DEN_W-1:0]    den,
	output logic                                done,
	output logic signed [ddo_pkg::DIV_W-1:0]    quot,
	output logic signed [ddo_pkg::DEN_W:0]      rem
);
	import ddo_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic                 neg_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DIV_W-1:0]     n_q;

	logic [DEN_W:0]       r1, r1n, r2, r2n;
	logic                 ge1, ge2;
	logic [DIV_W-1:0]     n1, n2;
	logic [DEN_W-1:0]     rem1;
	logic signed [DEN_W:0] rem_pos;

	always_comb begin
		r1   = {rem_q, n_q[DIV_W-1]};
		ge1  = (r1 >= {1'b0, den_q});
		r1n  = ge1 ? (r1 - {1'b0, den_q}) : r1;
		rem1 = r1n[DEN_W-1:0];
		n1   = {n_q[DIV_W-2:0], ge1};
		r2   = {rem1, n1[DIV_W-1]};
		ge2  = (r2 >= {1'b0, den_q});
		r2n  = ge2 ? (r2 - {1'b0, den_q}) : r2;
		n2   = {n1[DIV_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
			neg_q <= num[DIV_W-1];
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= n2;
			rem_q <= r2n[DEN_W-1:0];
		end
	end

	assign rem_pos = $signed({1'b0, rem_q});
	assign quot    = neg_q ? -$signed(n_q) : $signed(n_q);
	assign rem     = neg_q ? -rem_pos : rem_pos;
	assign done    = done_q;

endmodule

>>> sv/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving Q.30 cosine and sine.
// Depends on ddo_pkg for the arctangent table and gain.
module ddo_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ddo_pkg::COR_ZW-1:0] angle,
	output logic                              done,
	output logic signed [31:0]                cos_val,
	output logic signed [31:0]                sin_val
);
	import ddo_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [4:0]               it_q;
	logic                     neg_q;
	logic signed [COR_XW-1:0] x_q, y_q;
	logic signed [COR_ZW-1:0] z_q;

	logic signed [COR_XW-1:0] xs, ys, x_fin, y_fin;
	logic signed [COR_ZW-1:0] at;

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign at = atan_q24(it_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 5'd1;
				if (it_q == 5'(COR_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Angles beyond a quarter turn are folded by pi and the result negated.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			if (angle > Q24_HALF_PI) begin
				z_q   <= angle - Q24_PI;
				neg_q <= 1'b1;
			end else if (angle < -Q24_HALF_PI) begin
				z_q   <= angle + Q24_PI;
				neg_q <= 1'b1;
			end else begin
				z_q   <= angle;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign x_fin   = neg_q ? -x_q : x_q;
	assign y_fin   = neg_q ? -y_q : y_q;
	assign cos_val = x_fin[31:0];
	assign sin_val = y_fin[31:0];
	assign done    = done_q;

endmodule

>>> sv/ddo_dp.sv
// Odometry datapath: operand registers, pose state, multiplier, and the shared divider
// and CORDIC units, all driven by controller commands. Depends on ddo_pkg, ddo_div, ddo_cordic.
module ddo_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ddo_pkg::cmd_t          cmd,
	output ddo_pkg::status_t       status,
	input  logic signed [15:0]     front_left_ticks,
	input  logic signed [15:0]     rear_left_ticks,
	input  logic signed [15:0]     front_right_ticks,
	input  logic signed [15:0]     rear_right_ticks,
	input  logic        [23:0]     elapsed_us,
	input  logic        [23:0]     wheel_circumference,
	input  logic        [23:0]     track_width,
	input  logic        [15:0]     ticks_per_turn,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic signed [31:0]     pos_x,
	output logic signed [31:0]     pos_y,
	output logic signed [18:0]     heading,
	output logic signed [31:0]     vel_x,
	output logic signed [31:0]     vel_y,
	output logic signed [31:0]     vel_heading,
	output logic                   zero_time
);
	import ddo_pkg::*;

	// Item operands and intermediate results.
	logic signed [16:0] lsum_q, rsum_q;
	logic        [23:0] us_q;
	logic signed [31:0] dl_q, dr_q, s_q, dth_q;
	logic signed [19:0] ang_q;
	logic signed [18:0] hnext_q;
	logic signed [63:0] prod_q;
	logic signed [33:0] dx_q, dy_q;
	logic signed [31:0] vx_q, vy_q, vh_q;

	// Pose state.
	logic signed [31:0] x_acc_q, y_acc_q;
	logic signed [18:0] heading_q;

	// Result register.
	logic               out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, vel_h_q;
	logic signed [18:0] heading_out_q;
	logic               zero_time_q;

	// Divider and CORDIC hookup.
	logic                    div_start, div_done, cor_done;
	logic signed [DIV_W-1:0] div_num, div_quot;
	logic        [DEN_W-1:0] div_den;
	logic signed [DEN_W:0]   div_rem;
	logic signed [31:0]      cos_val, sin_val;

	// Combinational helpers.
	logic signed [24:0] circ_s;
	logic signed [41:0] wheel_prod;
	logic signed [16:0] wheel_sum;
	logic        [16:0] tpt2;
	logic signed [32:0] lr_diff, lr_sum, s_full;
	logic signed [48:0] th_num;
	logic signed [32:0] hsum;
	logic signed [33:0] hwrap, hsat;
	logic signed [25:0] rem_ext, ang_adj;
	logic signed [33:0] vel_d;
	logic signed [54:0] vel_num;
	logic signed [31:0] trig_sel;
	logic signed [63:0] prod_rnd;
	logic signed [33:0] d_rnd;

	assign circ_s     = $signed({1'b0, wheel_circumference});
	assign wheel_sum  = (cmd.op == OP_DIV_DR) ? rsum_q : lsum_q;
	assign wheel_prod = wheel_sum * circ_s;
	assign tpt2       = (ticks_per_turn == 16'd0) ? 17'd2 : {ticks_per_turn, 1'b0};

	assign lr_diff = 33'(dl_q) - 33'(dr_q);
	assign lr_sum  = 33'(dl_q) + 33'(dr_q);
	assign s_full  = (lr_sum + $signed({32'd0, lr_sum[32]})) >>> 1;
	assign th_num  = {lr_diff, 16'd0};

	// Heading update: one wrap by two pi, then clamp to the Q2.16 range.
	assign hsum = 33'(heading_q) + 33'(dth_q);
	always_comb begin
		if (hsum > Q16_PI) begin
			hwrap = 34'(hsum) - 34'(Q16_TWO_PI);
		end else if (hsum < -Q16_PI) begin
			hwrap = 34'(hsum) + 34'(Q16_TWO_PI);
		end else begin
			hwrap = 34'(hsum);
		end
		if (hwrap > HEAD_MAX) begin
			hsat = HEAD_MAX;
		end else if (hwrap < HEAD_MIN) begin
			hsat = HEAD_MIN;
		end else begin
			hsat = hwrap;
		end
	end

	// Remainder of the heading sum modulo two pi, folded into [-pi, pi].
	assign rem_ext = 26'(div_rem);
	always_comb begin
		if (rem_ext > 26'(Q16_PI)) begin
			ang_adj = rem_ext - 26'(Q16_TWO_PI);
		end else if (rem_ext < -26'(Q16_PI)) begin
			ang_adj = rem_ext + 26'(Q16_TWO_PI);
		end else begin
			ang_adj = rem_ext;
		end
	end

	always_comb begin
		case (cmd.op)
			OP_DIV_VY: vel_d = dy_q;
			OP_DIV_VH: vel_d = 34'(dth_q);
			default:   vel_d = dx_q;
		endcase
	end
	assign vel_num = vel_d * US_PER_S;

	always_comb begin
		div_start = 1'b1;
		div_num   = 56'(wheel_prod);
		div_den   = 24'(tpt2);
		case (cmd.op)
			OP_DIV_DL, OP_DIV_DR: begin
				div_num = 56'(wheel_prod);
				div_den = 24'(tpt2);
			end
			OP_DIV_TH: begin
				div_num = 56'(th_num);
				div_den = (track_width == 24'd0) ? 24'd1 : track_width;
			end
			OP_DIV_ANG: begin
				div_num = 56'(hsum);
				div_den = TWO_PI_DEN;
			end
			OP_DIV_VX, OP_DIV_VY, OP_DIV_VH: begin
				div_num = 56'(vel_num);
				div_den = us_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	ddo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	ddo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.op == OP_COR_GO),
		.angle   ({ang_q, 8'd0}),
		.done    (cor_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	// Step projection: round(s * trig / 2^30), multiplier output registered first.
	assign trig_sel = (cmd.op == OP_MUL_Y) ? sin_val : cos_val;
	assign prod_rnd = prod_q + RND_HALF;
	assign d_rnd    = prod_rnd[63:30];

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				lsum_q <= 17'(front_left_ticks) + 17'(rear_left_ticks);
				rsum_q <= 17'(front_right_ticks) + 17'(rear_right_ticks);
				us_q   <= elapsed_us;
			end
			OP_PUT_DL:  dl_q <= sat32(div_quot);
			OP_PUT_DR:  dr_q <= sat32(div_quot);
			OP_DIV_TH:  s_q  <= s_full[31:0];
			OP_PUT_TH:  dth_q <= sat32(div_quot);
			OP_DIV_ANG: hnext_q <= hsat[18:0];
			OP_PUT_ANG: ang_q <= ang_adj[19:0];
			OP_MUL_X:   prod_q <= s_q * trig_sel;
			OP_MUL_Y: begin
				prod_q <= s_q * trig_sel;
				dx_q   <= d_rnd;
			end
			OP_POSE: begin
				dy_q <= d_rnd;
				vx_q <= '0;
				vy_q <= '0;
				vh_q <= '0;
			end
			OP_PUT_VX: vx_q <= sat32(div_quot);
			OP_PUT_VY: vy_q <= sat32(div_quot);
			OP_PUT_VH: vh_q <= sat32(div_quot);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_acc_q   <= '0;
			y_acc_q   <= '0;
			heading_q <= '0;
		end else if (cmd.op == OP_POSE) begin
			x_acc_q   <= x_acc_q + dx_q[31:0];
			y_acc_q   <= y_acc_q + d_rnd[31:0];
			heading_q <= hnext_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_LOAD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD_OUT) begin
			pos_x_q       <= x_acc_q;
			pos_y_q       <= y_acc_q;
			heading_out_q <= heading_q;
			vel_x_q       <= vx_q;
			vel_y_q       <= vy_q;
			vel_h_q       <= vh_q;
			zero_time_q   <= (us_q == 24'd0);
		end
	end

	assign status.div_done  = div_done;
	assign status.cor_done  = cor_done;
	assign status.zero_time = (us_q == 24'd0);
	assign status.out_busy  = out_valid_q & ~out_ready;

	assign out_valid   = out_valid_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign heading     = heading_out_q;
	assign vel_x       = vel_x_q;
	assign vel_y       = vel_y_q;
	assign vel_heading = vel_h_q;
	assign zero_time   = zero_time_q;

endmodule

>>> sv/ddo_ctrl.sv
// Odometry controller: sequences one item through the datapath and its shared units.
// Depends on ddo_pkg for the state, command and status types.
module ddo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ddo_pkg::status_t  status,
	output ddo_pkg::cmd_t     cmd
);
	import ddo_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_DIV_DL;
				end
			end
			ST_DIV_DL: begin
				cmd.op  = OP_DIV_DL;
				state_d = ST_WAIT_DL;
			end
			ST_WAIT_DL: begin
				if (status.div_done) begin
					cmd.op  = OP_PUT_DL;
					state_d = ST_DIV_DR;
				end
			end
			ST_DIV_DR: begin
				cmd.op  = OP_DIV_DR;
				state_d = ST_WAIT_DR;
			end
			ST_WAIT_DR: begin
				if (status.div_done) begin
					cmd.op  = OP_PUT_DR;
					state_d = ST_DIV_TH;
				end
			end
			ST_DIV_TH: begin
				cmd.op  = OP_DIV_TH;
				state_d = ST_WAIT_TH;
			end
			ST_WAIT_TH: begin
				if (status.div_done) begin
					cmd.op  = OP_PUT_TH;
					state_d = ST_DIV_ANG;
				end
			end
			ST_DIV_ANG: begin
				cmd.op  = OP_DIV_ANG;
				state_d = ST_WAIT_ANG;
			end
			ST_WAIT_ANG: begin
				if (status.div_done) begin
					cmd.op  = OP_PUT_ANG;
					state_d = ST_COR;
				end
			end
			ST_COR: begin
				cmd.op  = OP_COR_GO;
				state_d = ST_WAIT_COR;
			end
			ST_WAIT_COR: begin
				if (status.cor_done) begin
					state_d = ST_MUL_X;
				end
			end
			ST_MUL_X: begin
				cmd.op  = OP_MUL_X;
				state_d = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.op  = OP_MUL_Y;
				state_d = ST_POSE;
			end
			ST_POSE: begin
				cmd.op  = OP_POSE;
				state_d = status.zero_time ? ST_OUT : ST_DIV_VX;
			end
			ST_DIV_VX: begin
				cmd.op  = OP_DIV_VX;
				state_d = ST_WAIT_VX;
			end
			ST_WAIT_VX: begin
				if (status.div_done) begin
					cmd.op  = OP_PUT_VX;
					state_d = ST_DIV_VY;
				end
			end
			ST_DIV_VY: begin
				cmd.op  = OP_DIV_VY;
				state_d = ST_WAIT_VY;
			end
			ST_WAIT_VY: begin
				if (status.div_done) begin
					cmd.op  = OP_PUT_VY;
					state_d = ST_DIV_VH;
				end
			end
			ST_DIV_VH: begin
				cmd.op  = OP_DIV_VH;
				state_d = ST_WAIT_VH;
			end
			ST_WAIT_VH: begin
				if (status.div_done) begin
					cmd.op  = OP_PUT_VH;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!status.out_busy) begin
					cmd.op  = OP_LOAD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> sv/differential_drive_odometry_unit.sv
// Each sample passes through seven divisions on the shared radix-4 divider (four when the
// elapsed time is zero and the velocities are skipped), one CORDIC rotation, the two
// projection multiplies, the pose update and the load of the result register.
// One sample is in work at a time, so a new sample is taken only once the last is loaded; the
// next sample transfers while the last pose still waits, and a stalled pose delays the next.
// Reset (arst_n low, asynchronous) clears the pose to zero, empties the result register
// and loads the configuration registers with their default geometry.
module differential_drive_odometry_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	ddo_sample_if.sink                     sample,
	ddo_pose_if.source                     pose,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ddo_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import ddo_pkg::*;

	// Geometry registers. The user must write them only while no sample is in work; the block does
	// not enforce this itself, and the datapath reads them directly without a shadow copy.
	logic [23:0] circ_q;
	logic [23:0] track_q;
	logic [15:0] ticks_q;
	logic        wr_en;

	cmd_t    cmd;
	status_t status;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q  <= CIRC_RESET;
			track_q <= TRACK_RESET;
			ticks_q <= TICKS_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_CIRC:  circ_q  <= pwdata[23:0];
				REG_TRACK: track_q <= pwdata[23:0];
				REG_TICKS: ticks_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Reads return the register's value; the unused slot reads as zero.
	always_comb begin
		case (paddr[3:2])
			REG_CIRC:  prdata = {8'd0, circ_q};
			REG_TRACK: prdata = {8'd0, track_q};
			REG_TICKS: prdata = {16'd0, ticks_q};
			default:   prdata = 32'd0;
		endcase
	end

	// The controller walks each sample through wheel distances, heading change, angle reduction,
	// the CORDIC, position update and, unless the elapsed time is zero, the three velocities.
	ddo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath owns the pose state and the result register, which holds a
	// finished pose until the sink takes it.
	ddo_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.front_left_ticks    (sample.front_left_ticks),
		.rear_left_ticks     (sample.rear_left_ticks),
		.front_right_ticks   (sample.front_right_ticks),
		.rear_right_ticks    (sample.rear_right_ticks),
		.elapsed_us          (sample.elapsed_us),
		.wheel_circumference (circ_q),
		.track_width         (track_q),
		.ticks_per_turn      (ticks_q),
		.out_ready           (pose.ready),
		.out_valid           (pose.valid),
		.pos_x               (pose.pos_x),
		.pos_y               (pose.pos_y),
		.heading             (pose.heading),
		.vel_x               (pose.vel_x),
		.vel_y               (pose.vel_y),
		.vel_heading         (pose.vel_heading),
		.zero_time           (pose.zero_time)
	);

endmodule

>>> sv/ddo_checker.sv
// Port-level checks for the odometry unit, bound onto the top level.
// Depends only on the top level's ports.
module ddo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pos_x,
	input logic [31:0] vel_x,
	input logic [31:0] vel_y,
	input logic [31:0] vel_heading,
	input logic        zero_time
);

	// A pending pose is not dropped, and its pos_x does not change, while the sink stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pose dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x))
		else $error("pose changed while stalled");

	// Only one sample is in work: a transfer closes the input for the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while another is in work");

	// A zero elapsed time forces all three velocities to zero.
	a_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_time |-> vel_x == 32'd0 && vel_y == 32'd0 && vel_heading == 32'd0)
		else $error("nonzero velocity with zero elapsed time");

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (pose.valid),
	.out_ready   (pose.ready),
	.pos_x       (pose.pos_x),
	.vel_x       (pose.vel_x),
	.vel_y       (pose.vel_y),
	.vel_heading (pose.vel_heading),
	.zero_time   (pose.zero_time)
);

>>> test/ddo_pose_checker.sv
`timescale 1ns / 100ps
// Pose checker for the odometry unit: watches the sample, pose and configuration buses.
// It predicts every pose and compares it; it depends on ddo_pkg and ddo_channels.sv.
module ddo_pose_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	ddo_sample_if                       sample,
	ddo_pose_if                         pose,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ddo_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic                        pready,
	output int                          errors,
	output int                          pending
);
	import ddo_pkg::*;

	typedef struct {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [18:0] heading;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] vel_heading;
		logic        zero_time;
	} pose_t;

	localparam longint ATAN_Q24 [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2
	};

	pose_t       poses_due[$];
	logic [23:0] circ, track;
	logic [15:0] ticks;
	logic [31:0] x_pos, y_pos;
	longint      head;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Rotation-mode CORDIC in Q.30, angle in Q.24; the outer half plane is folded by pi.
	function automatic void rotate(input longint ang, output longint c, output longint s);
		longint x, y, z, xs, ys;
		bit flip;
		x = 652032874; y = 0; z = ang; flip = 0;
		if (z > 26353589) begin
			z -= 52707179; flip = 1;
		end else if (z < -26353589) begin
			z += 52707179; flip = 1;
		end
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_Q24[i];
			end else begin
				x += ys; y -= xs; z += ATAN_Q24[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint rate(input longint d, input longint us);
		return clamp32((d * 1000000) / us);
	endfunction

	// Dead-reckoning step: updates the pose state and returns the pose it reports.
	function automatic pose_t advance_pose(input longint fl, rl, fr, rr, us);
		longint tpt, trk, dl, dr, mean, dth, a, c, sn, dx, dy, h;
		pose_t p;
		tpt = (ticks == 0) ? 1 : ticks;
		trk = (track == 0) ? 1 : track;
		dl = clamp32(((fl + rl) * longint'(circ)) / (2 * tpt));
		dr = clamp32(((fr + rr) * longint'(circ)) / (2 * tpt));
		mean = (dl + dr) / 2;
		dth = clamp32(((dl - dr) * 65536) / trk);
		a = (head + dth) % 411775;
		if (a > 205887) a -= 411775;
		else if (a < -205887) a += 411775;
		rotate(a * 256, c, sn);
		dx = (mean * c + (64'sd1 <<< 29)) >>> 30;
		dy = (mean * sn + (64'sd1 <<< 29)) >>> 30;
		x_pos += dx[31:0];
		y_pos += dy[31:0];
		h = head + dth;
		if (h > 205887) h -= 411775;
		else if (h < -205887) h += 411775;
		if (h > 262143) h = 262143;
		else if (h < -262144) h = -262144;
		head = h;
		p.pos_x = x_pos;
		p.pos_y = y_pos;
		p.heading = h[18:0];
		p.zero_time = (us == 0);
		if (us == 0) begin
			p.vel_x = '0; p.vel_y = '0; p.vel_heading = '0;
		end else begin
			p.vel_x = 32'(rate(dx, us));
			p.vel_y = 32'(rate(dy, us));
			p.vel_heading = 32'(rate(dth, us));
		end
		return p;
	endfunction

	task automatic compare(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	assign pending = poses_due.size();

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		if (!arst_n) begin
			circ = CIRC_RESET; track = TRACK_RESET; ticks = TICKS_RESET;
			x_pos = '0; y_pos = '0; head = 0;
			poses_due.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_CIRC:  circ = pwdata[23:0];
					REG_TRACK: track = pwdata[23:0];
					REG_TICKS: ticks = pwdata[15:0];
					default: ;
				endcase
			end
			if (sample.valid && sample.ready) begin
				poses_due.push_back(advance_pose(sample.front_left_ticks,
					sample.rear_left_ticks, sample.front_right_ticks,
					sample.rear_right_ticks, longint'(sample.elapsed_us)));
			end
			if (pose.valid && pose.ready) begin
				if (poses_due.size() == 0) begin
					errors++;
					$display("%0t: pose transfer with no sample outstanding", $time);
				end else begin
					want = poses_due.pop_front();
					compare("pos_x", want.pos_x, pose.pos_x);
					compare("pos_y", want.pos_y, pose.pos_y);
					compare("heading", {13'd0, want.heading}, {13'd0, pose.heading});
					compare("vel_x", want.vel_x, pose.vel_x);
					compare("vel_y", want.vel_y, pose.vel_y);
					compare("vel_heading", want.vel_heading, pose.vel_heading);
					compare("zero_time", 32'(want.zero_time), 32'(pose.zero_time));
				end
			end
		end
	end
endmodule

>>> test/differential_drive_odometry_unit_tb.sv
`timescale 1ns / 100ps
// Top of the odometry unit testbench: clock, reset, register writes, wheel samples, verdict.
// Depends on ddo_pkg, ddo_channels.sv, the unit itself and ddo_pose_checker.sv.
module differential_drive_odometry_unit_tb;
	import ddo_pkg::*;

	// HANG_LIMIT lies far beyond the time one sample takes, stalled pose included; that long
	// with no transfer of any kind means the block has hung.
	localparam int HANG_LIMIT = 3000;
	localparam int SETTLE     = 200;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 errors, pending;
	int                 samples_sent, still_samples, max_geometry_samples;
	int                 quiet_cycles = 0;
	bit                 steady;	// when set, neither side inserts gaps

	ddo_sample_if sample ();
	ddo_pose_if   pose ();

	differential_drive_odometry_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample.sink),
		.pose    (pose.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ddo_pose_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample),
		.pose    (pose),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The watchdog restarts on any transfer: sample, pose or register write.
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (pose.valid && pose.ready) ||
		    (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
			$display("[differential_drive_odometry_unit] ERROR");
			$finish;
		end
	end

	// Pose receiver: before every pose it may first hold ready low at random,
	// unless the steady stretch is on.
	initial begin
		int stall;
		pose.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				@(negedge clk);
				pose.ready <= 1'b0;
			end
			@(negedge clk);
			pose.ready <= 1'b1;
			do @(posedge clk); while (!pose.valid);
		end
	end

	// A register write: a setup phase, then an access phase; pready is always high.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00}); pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Geometry changes only with the block idle: the input closed, every pose back,
	// then a settling pause.
	task automatic set_geometry(input logic [23:0] circ, track, input logic [15:0] ticks);
		@(negedge clk);
		sample.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_CIRC, 32'(circ));
		write_reg(REG_TRACK, 32'(track));
		write_reg(REG_TICKS, 32'(ticks));
	endtask

	// One sample transfer. Valid is only touched once per falling edge, so a back-to-back
	// sample keeps valid high while its fields change.
	task automatic send_sample(input logic signed [15:0] fl, rl, fr, rr,
	                           input logic [23:0] us);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			sample.valid <= 1'b0;
		end
		@(negedge clk);
		sample.valid <= 1'b1;
		sample.front_left_ticks <= fl;
		sample.rear_left_ticks <= rl;
		sample.front_right_ticks <= fr;
		sample.rear_right_ticks <= rr;
		sample.elapsed_us <= us;
		do @(posedge clk); while (!sample.ready);
		samples_sent++;
		if (us == 0) still_samples++;
	endtask

	// Random samples: mostly realistic motion at an encoder rate of tens of hertz, with
	// some full-range noise so that every bit of every field moves.
	task automatic random_samples(input int count);
		logic signed [15:0] t [4];
		logic [23:0] us;
		int style;
		for (int n = 0; n < count; n++) begin
			if (n % 70 == 0) steady = ($urandom_range(0, 2) == 0);
			style = $urandom_range(0, 9);
			for (int k = 0; k < 4; k++) begin
				t[k] = (style < 3) ? 16'($urandom) : 16'($signed($urandom_range(0, 400)) - 200);
			end
			if (style == 9) begin
				t[1] = t[0]; t[2] = t[0]; t[3] = t[0];	// straight-line travel
			end
			case ($urandom_range(0, 9))
				0:       us = '0;
				1:       us = 24'($urandom);
				2:       us = 24'($urandom_range(1, 16));
				default: us = 24'($urandom_range(10000, 100000));
			endcase
			send_sample(t[0], t[1], t[2], t[3], us);
		end
		steady = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		sample.valid = 1'b0;
		sample.front_left_ticks = '0;
		sample.rear_left_ticks = '0;
		sample.front_right_ticks = '0;
		sample.rear_right_ticks = '0;
		sample.elapsed_us = '0;
		steady = 0;
		samples_sent = 0;
		still_samples = 0;
		max_geometry_samples = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default geometry, written back explicitly, then directed corner samples.
		set_geometry(CIRC_RESET, TRACK_RESET, TICKS_RESET);
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'd0);
		send_sample(16'sd30, 16'sd30, 16'sd30, 16'sd30, 24'd50000);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 24'd1);
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 24'hFFFFFF);
		send_sample(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 24'd0);
		send_sample(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 24'd1);
		send_sample(16'sd10, 16'sd12, -16'sd10, -16'sd12, 24'd20000);
		send_sample(-16'sd5, 16'sd5, 16'sd7, -16'sd7, 24'd33333);
		for (int k = 0; k < 6; k++) begin
			send_sample(16'sd400, 16'sd400, -16'sd400, -16'sd400, 24'd40000);	// spin past pi
		end
		random_samples(200);

		// Largest scale: distances, heading change and velocities all saturate.
		set_geometry(24'hFFFFFF, 24'd1, 16'd1);
		send_sample(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 24'd1);
		send_sample(16'sd1, 16'sd0, 16'sd0, 16'sd0, 24'd0);
		random_samples(160);
		max_geometry_samples = 162;

		// Zero track width and zero ticks per turn are each treated as a value of one.
		set_geometry(24'd1, 24'd0, 16'd0);
		send_sample(16'sd32767, -16'sd32768, 16'sd1, 16'sd0, 24'd1000);
		random_samples(160);

		// Smallest nonzero values, then the largest divisors.
		set_geometry(24'd1, 24'd1, 16'd1);
		random_samples(160);
		set_geometry(24'd1, 24'hFFFFFF, 16'hFFFF);
		send_sample(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 24'd1);
		random_samples(100);

		// A random geometry in the working range to close.
		set_geometry(24'($urandom_range(1000, 200000)), 24'($urandom_range(1000, 200000)),
		             16'($urandom_range(1, 4096)));
		random_samples(250);

		@(negedge clk);
		sample.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d wheel samples (%0d with zero elapsed time, %0d at full scale)",
		         samples_sent, still_samples, max_geometry_samples);
		$display("across six geometry settings including saturating and zero-divisor ones.");
		if (errors == 0) begin
			$display("[differential_drive_odometry_unit] OK");
		end else begin
			$display("[differential_drive_odometry_unit] ERROR");
		end
		$finish;
	end
endmodule

>>> filelist.f
sv/ddo_pkg.sv
sv/ddo_channels.sv
sv/ddo_div.sv
sv/ddo_cordic.sv
sv/ddo_dp.sv
sv/ddo_ctrl.sv
sv/differential_drive_odometry_unit.sv
sv/ddo_checker.sv
test/ddo_pose_checker.sv
test/differential_drive_odometry_unit_tb.sv
